FILE: design/afhc_pkg.sv
// Shared types, constants and lookup tables for the audio frame header checker.
`default_nettype none

package afhc_pkg;

   // Default depth of the queue between the front and back parts.
   localparam int AFHC_QUEUE_DEPTH = 4;

   // Reciprocal of 441 scaled by two to the thirtieth, rounded down.
   localparam int RECIP_441_SHIFT = 30;
   localparam logic [21:0] RECIP_441 = 22'((64'd1 << RECIP_441_SHIFT) / 64'd441);
   localparam logic [8:0] DIVISOR_441 = 9'd441;

   // Exact reciprocal of 3 for 16-bit dividends.
   localparam int RECIP_3_SHIFT = 17;
   localparam logic [16:0] RECIP_3 = 17'd43691;

   // Fault codes in priority order.
   typedef enum logic [2:0] {
      FAULT_NONE     = 3'd0,
      FAULT_VERSION  = 3'd1,
      FAULT_LAYER    = 3'd2,
      FAULT_BITRATE  = 3'd3,
      FAULT_RATE     = 3'd4,
      FAULT_EMPHASIS = 3'd5,
      FAULT_L2_PAIR  = 3'd6
   } afhc_fault_type;

   // How the back part turns the dividend into the frame length.
   typedef enum logic [2:0] {
      DIV_SHR4       = 3'd0,
      DIV_SHR5       = 3'd1,
      DIV_THIRD_SHR4 = 3'd2,
      DIV_THIRD_SHR3 = 3'd3,
      DIV_BY_441     = 3'd4
   } afhc_div_op_type;

   // Header field codes.
   localparam logic [1:0] VER_MPEG1   = 2'd3;
   localparam logic [1:0] VER_MPEG2   = 2'd2;
   localparam logic [1:0] LAYER_ONE   = 2'd3;
   localparam logic [1:0] LAYER_TWO   = 2'd2;
   localparam logic [1:0] LAYER_RSVD  = 2'd0;
   localparam logic [1:0] RATE_RSVD   = 2'd3;
   localparam logic [1:0] MODE_SINGLE = 2'd3;
   localparam logic [1:0] EMPH_RSVD   = 2'd2;
   localparam logic [3:0] BIDX_FREE   = 4'd0;
   localparam logic [3:0] BIDX_BAD    = 4'd15;

   // Bitrate rows: MPEG-1 L1, MPEG-1 L2, MPEG-1 L3, MPEG-2 L1, MPEG-2 L2/L3.
   localparam logic [2:0] ROW_M1_L1 = 3'd0;
   localparam logic [2:0] ROW_M1_L2 = 3'd1;
   localparam logic [2:0] ROW_M1_L3 = 3'd2;
   localparam logic [2:0] ROW_M2_L1 = 3'd3;
   localparam logic [2:0] ROW_M2_LX = 3'd4;

   localparam logic [8:0] KBPS_TABLE [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   localparam logic [15:0] RATE_MPEG1 [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
   localparam logic [15:0] RATE_MPEG2 [4] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};

   // One classified header waiting for the back part.
   typedef struct packed {
      afhc_fault_type  fault;
      logic            free_format;
      logic [8:0]      bitrate_kbps;
      logic [15:0]     sample_rate_hz;
      logic [10:0]     frame_samples;
      logic [2:0]      pad_bytes;
      logic [19:0]     dividend;
      afhc_div_op_type div_op;
   } afhc_entry_type;

endpackage

`default_nettype wire

FILE: design/afhc_front.sv
// Front part: decodes and classifies one header word per cycle.
`default_nettype none

module afhc_front (
   input  wire logic [31:0]           header_word,
   output afhc_pkg::afhc_entry_type   entry
);
   import afhc_pkg::*;

   logic [1:0]   ver;
   logic [1:0]   lay;
   logic [3:0]   bidx;
   logic [1:0]   ridx;
   logic         pad;
   logic [1:0]   mode;
   logic [1:0]   emph;
   logic         ver_ok;
   logic         mpeg1;
   logic         lay_ok;
   logic [2:0]   row;
   logic [8:0]   kbps;
   logic [15:0]  rate;
   logic [10:0]  samples;
   logic [7:0]   samples_div8;
   logic         pair_ok;
   logic [11:0]  factor;
   logic [20:0]  product;
   afhc_fault_type  fault;
   afhc_div_op_type div_op;

   // Field extraction.
   assign ver    = header_word[20:19];
   assign lay    = header_word[18:17];
   assign bidx   = header_word[15:12];
   assign ridx   = header_word[11:10];
   assign pad    = header_word[9];
   assign mode   = header_word[7:6];
   assign emph   = header_word[1:0];
   assign ver_ok = (ver == VER_MPEG1) || (ver == VER_MPEG2);
   assign mpeg1  = (ver == VER_MPEG1);
   assign lay_ok = (lay != LAYER_RSVD);

   // Table row, bitrate, sample rate and frame size.
   always_comb begin
      case (lay)
         LAYER_ONE: row = mpeg1 ? ROW_M1_L1 : ROW_M2_L1;
         LAYER_TWO: row = mpeg1 ? ROW_M1_L2 : ROW_M2_LX;
         default:   row = mpeg1 ? ROW_M1_L3 : ROW_M2_LX;
      endcase
      kbps    = '0;
      rate    = '0;
      samples = '0;
      if (ver_ok) begin
         rate = mpeg1 ? RATE_MPEG1[ridx] : RATE_MPEG2[ridx];
         if (lay_ok) begin
            kbps = KBPS_TABLE[row][bidx];
            if (lay == LAYER_ONE) begin
               samples = 11'd384;
            end else if (lay == LAYER_TWO || mpeg1) begin
               samples = 11'd1152;
            end else begin
               samples = 11'd576;
            end
         end
      end
   end

   // Layer II bitrate and channel mode pairing.
   always_comb begin
      case (kbps)
         9'd32, 9'd48, 9'd56, 9'd80:    pair_ok = (mode == MODE_SINGLE);
         9'd224, 9'd256, 9'd320, 9'd384: pair_ok = (mode != MODE_SINGLE);
         default:                        pair_ok = 1'b1;
      endcase
   end

   // First failing check wins.
   always_comb begin
      if (!ver_ok) begin
         fault = FAULT_VERSION;
      end else if (!lay_ok) begin
         fault = FAULT_LAYER;
      end else if (bidx == BIDX_BAD) begin
         fault = FAULT_BITRATE;
      end else if (ridx == RATE_RSVD) begin
         fault = FAULT_RATE;
      end else if (emph == EMPH_RSVD) begin
         fault = FAULT_EMPHASIS;
      end else if (mpeg1 && lay == LAYER_TWO && !pair_ok) begin
         fault = FAULT_L2_PAIR;
      end else begin
         fault = FAULT_NONE;
      end
   end

   // The frame length is (samples / 8) * kbps * 1000 / rate. The 44.1 kHz
   // family becomes a division by 441 after scaling by 10 or 20; the other
   // rates reduce to shifts with an optional division by 3.
   assign samples_div8 = samples[10:3];
   always_comb begin
      factor = {4'd0, samples_div8};
      div_op = DIV_SHR4;
      case (ridx)
         2'd0: begin
            factor = mpeg1 ? (12'(samples_div8) * 12'd10) : (12'(samples_div8) * 12'd20);
            div_op = DIV_BY_441;
         end
         2'd1: div_op = mpeg1 ? DIV_THIRD_SHR4 : DIV_THIRD_SHR3;
         2'd2: div_op = mpeg1 ? DIV_SHR5 : DIV_SHR4;
         default: div_op = DIV_SHR4;
      endcase
   end
   assign product = kbps * factor;

   assign entry.fault          = fault;
   assign entry.free_format    = (bidx == BIDX_FREE);
   assign entry.bitrate_kbps   = kbps;
   assign entry.sample_rate_hz = rate;
   assign entry.frame_samples  = samples;
   assign entry.pad_bytes      = pad ? ((lay == LAYER_ONE) ? 3'd4 : 3'd1) : 3'd0;
   assign entry.dividend       = product[19:0];
   assign entry.div_op         = div_op;

endmodule

`default_nettype wire

FILE: design/afhc_queue.sv
// Short queue of classified headers between the front and back parts.
`default_nettype none

module afhc_queue #(
   parameter int DEPTH = afhc_pkg::AFHC_QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  afhc_pkg::afhc_entry_type       push_entry,
   input  wire logic                      pop,
   output afhc_pkg::afhc_entry_type       head_entry,
   output logic                           not_empty,
   output logic                           full
);
   import afhc_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   afhc_entry_type     slot_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff;
   logic [IDX_W-1:0]   wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff;
   logic [IDX_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == FULL_CNT);
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/afhc_back.sv
// Back part: two-stage pipeline that finishes the frame length division.
`default_nettype none

module afhc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  afhc_pkg::afhc_entry_type   head_entry,
   input  wire logic                  head_valid,
   output logic                       head_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_header_ok,
   output logic [2:0]                 rsp_fault_code,
   output logic                       rsp_free_format,
   output logic [8:0]                 rsp_bitrate_kbps,
   output logic [15:0]                rsp_sample_rate_hz,
   output logic [10:0]                rsp_frame_samples,
   output logic [10:0]                rsp_frame_bytes
);
   import afhc_pkg::*;

   logic            advance;
   logic            s1_valid_ff;
   afhc_entry_type  s1_entry_ff;
   logic [11:0]     s1_quot_ff;
   logic [11:0]     s1_quot_in;
   logic [15:0]     third_arg;
   logic [32:0]     third_prod;
   logic [41:0]     recip_prod;
   logic [20:0]     back_prod;
   logic [20:0]     remainder;
   logic [11:0]     quot_final;
   logic [11:0]     bytes_sum;
   logic            out_valid_ff;
   logic            out_ok_ff;
   logic [2:0]      out_fault_ff;
   logic            out_free_ff;
   logic [8:0]      out_kbps_ff;
   logic [15:0]     out_rate_ff;
   logic [10:0]     out_samples_ff;
   logic [10:0]     out_bytes_ff;
   logic [10:0]     out_bytes_in;

   // The whole pipeline moves unless a finished result is held by the sink.
   assign advance  = !(out_valid_ff && rsp_stall);
   assign head_pop = advance && head_valid;

   // Stage one: quotient estimate by shift or by reciprocal multiplication.
   assign third_arg = (head_entry.div_op == DIV_THIRD_SHR4) ?
                      head_entry.dividend[19:4] : head_entry.dividend[18:3];
   assign third_prod = third_arg * RECIP_3;
   assign recip_prod = head_entry.dividend * RECIP_441;

   always_comb begin
      case (head_entry.div_op)
         DIV_SHR4:       s1_quot_in = head_entry.dividend[15:4];
         DIV_SHR5:       s1_quot_in = head_entry.dividend[16:5];
         DIV_THIRD_SHR4,
         DIV_THIRD_SHR3: s1_quot_in = third_prod[RECIP_3_SHIFT +: 12];
         DIV_BY_441:     s1_quot_in = recip_prod[RECIP_441_SHIFT +: 12];
         default:        s1_quot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_entry_ff <= head_entry;
         s1_quot_ff  <= s1_quot_in;
      end
   end

   // Stage two: the estimate for 441 may be one low; correct it once.
   assign back_prod  = s1_quot_ff * DIVISOR_441;
   assign remainder  = {1'b0, s1_entry_ff.dividend} - back_prod;
   always_comb begin
      quot_final = s1_quot_ff;
      if (s1_entry_ff.div_op == DIV_BY_441 && remainder >= {12'd0, DIVISOR_441}) begin
         quot_final = s1_quot_ff + 1'b1;
      end
   end

   // Free format adds padding only; any fault clears the length.
   assign bytes_sum = (s1_entry_ff.free_format ? 12'd0 : quot_final)
                      + {9'd0, s1_entry_ff.pad_bytes};
   assign out_bytes_in = (s1_entry_ff.fault == FAULT_NONE) ? bytes_sum[10:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ok_ff      <= (s1_entry_ff.fault == FAULT_NONE);
         out_fault_ff   <= s1_entry_ff.fault;
         out_free_ff    <= s1_entry_ff.free_format;
         out_kbps_ff    <= s1_entry_ff.bitrate_kbps;
         out_rate_ff    <= s1_entry_ff.sample_rate_hz;
         out_samples_ff <= s1_entry_ff.frame_samples;
         out_bytes_ff   <= out_bytes_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_header_ok      = out_ok_ff;
   assign rsp_fault_code     = out_fault_ff;
   assign rsp_free_format    = out_free_ff;
   assign rsp_bitrate_kbps   = out_kbps_ff;
   assign rsp_sample_rate_hz = out_rate_ff;
   assign rsp_frame_samples  = out_samples_ff;
   assign rsp_frame_bytes    = out_bytes_ff;

endmodule

`default_nettype wire

FILE: design/audio_frame_header_check_top.sv
// Top level of the audio frame header checker.
//
//   Channel   Direction  Ports                          Moves
//   req       in         req_valid, req_stall, req_*    one 32-bit header word
//   rsp       out        rsp_valid, rsp_stall, rsp_*    one decoded header result
//
// One header transaction is accepted per cycle while the queue has room.
// An accepted header is written into the queue, then taken into the reciprocal multiply stage,
// then through the correction stage into the output register.
// The two multiply stages in the back part set the clock period.
// Reset clears the queue and all valid flags; no clearing pass is needed.
// A stall on rsp freezes the back pipeline; the queue keeps taking
// transactions until it holds QUEUE_DEPTH entries.
`default_nettype none

module audio_frame_header_check_top #(
   parameter int QUEUE_DEPTH = afhc_pkg::AFHC_QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [31:0]   req_header_word,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_header_ok,
   output logic [2:0]         rsp_fault_code,
   output logic               rsp_free_format,
   output logic [8:0]         rsp_bitrate_kbps,
   output logic [15:0]        rsp_sample_rate_hz,
   output logic [10:0]        rsp_frame_samples,
   output logic [10:0]        rsp_frame_bytes
);
   import afhc_pkg::*;

   afhc_entry_type  front_entry;
   afhc_entry_type  head_entry;
   logic            queue_not_empty;
   logic            queue_full;
   logic            head_pop;

   assign req_stall = queue_full;

   // Classify each incoming header.
   afhc_front u_front (
      .header_word (req_header_word),
      .entry       (front_entry)
   );

   // Decouple the classifier from the arithmetic.
   afhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .pop        (head_pop),
      .head_entry (head_entry),
      .not_empty  (queue_not_empty),
      .full       (queue_full)
   );

   // Frame length arithmetic and output register.
   afhc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_entry         (head_entry),
      .head_valid         (queue_not_empty),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_header_ok      (rsp_header_ok),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_free_format    (rsp_free_format),
      .rsp_bitrate_kbps   (rsp_bitrate_kbps),
      .rsp_sample_rate_hz (rsp_sample_rate_hz),
      .rsp_frame_samples  (rsp_frame_samples),
      .rsp_frame_bytes    (rsp_frame_bytes)
   );

endmodule

`default_nettype wire

FILE: design/afhc_checker.sv
// Port-level checks for the audio frame header checker, bound to the top level.
`default_nettype none

module afhc_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_valid,
   input wire logic          rsp_stall,
   input wire logic          rsp_header_ok,
   input wire logic [2:0]    rsp_fault_code,
   input wire logic          rsp_free_format,
   input wire logic [8:0]    rsp_bitrate_kbps,
   input wire logic [10:0]   rsp_frame_bytes
);
   import afhc_pkg::*;

   // The pass flag agrees with the fault code.
   ok_matches_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_header_ok == (rsp_fault_code == FAULT_NONE)))
      else $error("header_ok disagrees with fault_code");

   // A rejected header reports no frame length.
   fault_clears_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_header_ok) |-> (rsp_frame_bytes == 11'd0))
      else $error("frame_bytes nonzero on a rejected header");

   // Free format carries no bitrate.
   free_has_no_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_free_format) |-> (rsp_bitrate_kbps == 9'd0))
      else $error("free format with nonzero bitrate");

   // A stalled result transaction stays put.
   stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_bytes)))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   reset_clears_valid: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind audio_frame_header_check_top afhc_checker u_afhc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_header_ok    (rsp_header_ok),
   .rsp_fault_code   (rsp_fault_code),
   .rsp_free_format  (rsp_free_format),
   .rsp_bitrate_kbps (rsp_bitrate_kbps),
   .rsp_frame_bytes  (rsp_frame_bytes)
);

`default_nettype wire

FILE: tb/sv/audio_frame_header_check_top_tb.sv
// Self-checking testbench for the audio frame header checker top level.
`default_nettype none

module audio_frame_header_check_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afhc_pkg::*;

   // Header codes that the package does not name.
   localparam logic [1:0] VER_MPEG25   = 2'd0;
   localparam logic [1:0] VER_RSVD     = 2'd1;
   localparam logic [1:0] LAYER_THREE  = 2'd1;
   localparam logic [1:0] MODE_STEREO  = 2'd0;
   localparam logic [1:0] EMPH_NONE    = 2'd0;
   localparam logic [1:0] EMPH_50_15   = 2'd1;
   localparam logic [1:0] EMPH_CCITT   = 2'd3;
   localparam logic [1:0] RATE_IDX_0   = 2'd0;
   localparam logic [1:0] RATE_IDX_1   = 2'd1;
   localparam logic [1:0] RATE_IDX_2   = 2'd2;

   localparam int RANDOM_HEADERS = 1075;
   localparam int LONG_HOLD      = 80;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 8;

   // One decoded header as the block reports it.
   typedef struct packed {
      logic           header_ok;
      afhc_fault_type fault;
      logic           free_format;
      logic [8:0]     kbps;
      logic [15:0]    rate_hz;
      logic [10:0]    samples;
      logic [10:0]    bytes;
   } header_result_type;

   typedef struct {
      logic [31:0]       word;
      header_result_type res;
   } pending_header_type;

   // Decodes accepted headers and compares results in arrival order.
   class frame_header_scoreboard_type;
      pending_header_type pending_q[$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        fault_seen[7];

      function header_result_type decode_header(logic [31:0] w);
         logic [1:0]        ver, lay, ridx, mode, emph;
         logic [3:0]        bidx;
         logic              pad, mpeg1;
         logic [0:15][8:0]  kbps_row;
         logic [63:0]       num, den;
         logic [10:0]       slot;
         header_result_type e;
         ver  = w[20:19];
         lay  = w[18:17];
         bidx = w[15:12];
         ridx = w[11:10];
         pad  = w[9];
         mode = w[7:6];
         emph = w[1:0];
         mpeg1 = (ver == VER_MPEG1);
         e = '0;
         kbps_row = '0;

         // Rate and bitrate are only looked up for a known version.
         if (ver == VER_MPEG1 || ver == VER_MPEG2) begin
            case (ridx)
               RATE_IDX_0: e.rate_hz = mpeg1 ? 16'd44100 : 16'd22050;
               RATE_IDX_1: e.rate_hz = mpeg1 ? 16'd48000 : 16'd24000;
               RATE_IDX_2: e.rate_hz = mpeg1 ? 16'd32000 : 16'd16000;
               default:    e.rate_hz = 16'd0;
            endcase
            if (lay != LAYER_RSVD) begin
               if (mpeg1 && lay == LAYER_ONE) begin
                  kbps_row = {9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
                              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
               end else if (mpeg1 && lay == LAYER_TWO) begin
                  kbps_row = {9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
                              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
               end else if (mpeg1) begin
                  kbps_row = {9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
                              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
               end else if (lay == LAYER_ONE) begin
                  kbps_row = {9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
                              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
               end else begin
                  kbps_row = {9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
                              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
               end
               e.kbps = kbps_row[bidx];
               if (lay == LAYER_ONE)
                  e.samples = 11'd384;
               else if (lay == LAYER_TWO || mpeg1)
                  e.samples = 11'd1152;
               else
                  e.samples = 11'd576;
            end
         end

         // Only the first failing check is reported.
         if (!(ver == VER_MPEG1 || ver == VER_MPEG2))
            e.fault = FAULT_VERSION;
         else if (lay == LAYER_RSVD)
            e.fault = FAULT_LAYER;
         else if (bidx == BIDX_BAD)
            e.fault = FAULT_BITRATE;
         else if (ridx == RATE_RSVD)
            e.fault = FAULT_RATE;
         else if (emph == EMPH_RSVD)
            e.fault = FAULT_EMPHASIS;
         else if (mpeg1 && lay == LAYER_TWO &&
                  (((e.kbps == 9'd32 || e.kbps == 9'd48 || e.kbps == 9'd56 ||
                     e.kbps == 9'd80) && mode != MODE_SINGLE) ||
                   ((e.kbps == 9'd224 || e.kbps == 9'd256 || e.kbps == 9'd320 ||
                     e.kbps == 9'd384) && mode == MODE_SINGLE)))
            e.fault = FAULT_L2_PAIR;
         else
            e.fault = FAULT_NONE;

         // Frame length in whole bytes plus the padding slot.
         if (e.fault == FAULT_NONE) begin
            slot = (lay == LAYER_ONE) ? 11'd4 : 11'd1;
            if (bidx != BIDX_FREE) begin
               num = 64'(e.samples) * 64'(e.kbps) * 64'd1000;
               den = 64'(e.rate_hz) * 64'd8;
               e.bytes = 11'(num / den);
            end
            if (pad)
               e.bytes = e.bytes + slot;
         end

         e.header_ok   = (e.fault == FAULT_NONE);
         e.free_format = (bidx == BIDX_FREE);
         return e;
      endfunction

      function void note_header(logic [31:0] w);
         pending_header_type p;
         p.word = w;
         p.res  = decode_header(w);
         pending_q.push_back(p);
      endfunction

      function void compare_field(string name, logic [31:0] w, int unsigned want,
                                  int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t ns: header %08h %s expected %0d actual %0d",
                     $time, w, name, want, got);
         end
      endfunction

      function void check_result(header_result_type got);
         pending_header_type p;
         if (pending_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
            return;
         end
         p = pending_q.pop_front();
         checked++;
         fault_seen[p.res.fault]++;
         compare_field("header_ok", p.word, p.res.header_ok, got.header_ok);
         compare_field("fault_code", p.word, p.res.fault, got.fault);
         compare_field("free_format", p.word, p.res.free_format, got.free_format);
         compare_field("bitrate_kbps", p.word, p.res.kbps, got.kbps);
         compare_field("sample_rate_hz", p.word, p.res.rate_hz, got.rate_hz);
         compare_field("frame_samples", p.word, p.res.samples, got.samples);
         compare_field("frame_bytes", p.word, p.res.bytes, got.bytes);
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      function void flag_leftovers();
         foreach (pending_q[i]) begin
            mismatches++;
            $display("%0t ns: header %08h expected result %p, actual none",
                     $time, pending_q[i].word, pending_q[i].res);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_header_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_header_ok;
   logic [2:0]  rsp_fault_code;
   logic        rsp_free_format;
   logic [8:0]  rsp_bitrate_kbps;
   logic [15:0] rsp_sample_rate_hz;
   logic [10:0] rsp_frame_samples;
   logic [10:0] rsp_frame_bytes;

   header_result_type          rsp_seen;
   frame_header_scoreboard_type sb;
   bit                         send_gaps_on = 1'b1;
   bit                         recv_stalls_on = 1'b1;
   bit                         hold_request = 1'b0;
   int unsigned                cycle_count = 0;
   int unsigned                input_stall_cycles = 0;

   audio_frame_header_check_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_header_word    (req_header_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_header_ok      (rsp_header_ok),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_free_format    (rsp_free_format),
      .rsp_bitrate_kbps   (rsp_bitrate_kbps),
      .rsp_sample_rate_hz (rsp_sample_rate_hz),
      .rsp_frame_samples  (rsp_frame_samples),
      .rsp_frame_bytes    (rsp_frame_bytes)
   );

   // Free-running clock.
   always #2 clock = ~clock;

   assign rsp_seen = {rsp_header_ok, rsp_fault_code, rsp_free_format, rsp_bitrate_kbps,
                      rsp_sample_rate_hz, rsp_frame_samples, rsp_frame_bytes};

   // Observe every transaction on both channels at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_seen);
         if (req_valid && !req_stall)
            sb.note_header(req_header_word);
         if (req_valid && req_stall)
            input_stall_cycles++;
      end
   end

   // Hard limit on the length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("audio_frame_header_check_top_tb failed");
         $finish;
      end
   end

   // Builds a header from its checked fields; the unchecked bits are random.
   function automatic logic [31:0] make_header(logic [1:0] ver, logic [1:0] lay,
                                               logic [3:0] bidx, logic [1:0] ridx,
                                               logic pad, logic [1:0] mode,
                                               logic [1:0] emph);
      logic [31:0] w;
      w = $urandom;
      w[20:19] = ver;
      w[18:17] = lay;
      w[15:12] = bidx;
      w[11:10] = ridx;
      w[9]     = pad;
      w[7:6]   = mode;
      w[1:0]   = emph;
      return w;
   endfunction

   // Mostly well-formed headers with random content; the rest is raw noise.
   function automatic logic [31:0] random_header();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         w[20:19] = $urandom_range(0, 1) ? VER_MPEG1 : VER_MPEG2;
         w[18:17] = 2'($urandom_range(1, 3));
         w[15:12] = 4'($urandom_range(0, 14));
         w[11:10] = 2'($urandom_range(0, 2));
         if (w[1:0] == EMPH_RSVD)
            w[1:0] = $urandom_range(0, 1) ? EMPH_NONE : EMPH_CCITT;
      end
      return w;
   endfunction

   // Offers one header, after a random gap when gaps are on, and waits until it is taken.
   task automatic send_header(input logic [31:0] w);
      int unsigned gap;
      gap = send_gaps_on ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_header_word <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering headers until every result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Result side: random stall before each result while stalls are on, plus one long hold on request.
   initial begin : rsp_side
      int unsigned hold;
      int unsigned taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 100 == 0)
            recv_stalls_on = ($urandom_range(0, 2) != 0);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = recv_stalls_on ? $urandom_range(0, 15) : 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Main sequence: directed headers, then random traffic, then the final check.
   initial begin : req_side
      logic [31:0] directed_q[$];
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, every fault and its priority, and the frame length corners.
      directed_q.push_back(32'h0000_0000);
      directed_q.push_back(32'hFFFF_FFFF);
      directed_q.push_back(make_header(VER_MPEG25, LAYER_THREE, 4'd9, RATE_IDX_0, 1'b0,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_RSVD, LAYER_RSVD, BIDX_BAD, RATE_RSVD, 1'b1,
                                       MODE_STEREO, EMPH_RSVD));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_RSVD, BIDX_BAD, RATE_RSVD, 1'b0,
                                       MODE_STEREO, EMPH_RSVD));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_THREE, BIDX_BAD, RATE_RSVD, 1'b0,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_ONE, 4'd5, RATE_RSVD, 1'b1,
                                       MODE_STEREO, EMPH_RSVD));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_TWO, 4'd1, RATE_IDX_0, 1'b0,
                                       MODE_STEREO, EMPH_RSVD));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_ONE, BIDX_FREE, RATE_IDX_0, 1'b1,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_THREE, BIDX_FREE, RATE_IDX_1, 1'b1,
                                       MODE_SINGLE, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_TWO, BIDX_FREE, RATE_IDX_2, 1'b0,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_TWO, 4'd1, RATE_IDX_1, 1'b0,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_TWO, 4'd1, RATE_IDX_1, 1'b1,
                                       MODE_SINGLE, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_TWO, 4'd14, RATE_IDX_2, 1'b0,
                                       MODE_SINGLE, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_TWO, 4'd14, RATE_IDX_2, 1'b1,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_TWO, 4'd8, RATE_IDX_0, 1'b1,
                                       MODE_SINGLE, EMPH_50_15));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_TWO, 4'd1, RATE_IDX_0, 1'b0,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_ONE, 4'd14, RATE_IDX_2, 1'b1,
                                       MODE_STEREO, EMPH_CCITT));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_THREE, 4'd9, RATE_IDX_0, 1'b1,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG1, LAYER_THREE, 4'd14, RATE_IDX_2, 1'b0,
                                       MODE_SINGLE, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_THREE, 4'd14, RATE_IDX_2, 1'b1,
                                       MODE_STEREO, EMPH_NONE));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_ONE, 4'd14, RATE_IDX_1, 1'b1,
                                       MODE_SINGLE, EMPH_CCITT));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_THREE, 4'd1, RATE_IDX_0, 1'b0,
                                       MODE_STEREO, EMPH_50_15));
      directed_q.push_back(make_header(VER_MPEG2, LAYER_ONE, 4'd1, RATE_IDX_0, 1'b1,
                                       MODE_STEREO, EMPH_NONE));
      foreach (directed_q[i])
         send_header(directed_q[i]);
      drain_results();

      // Random traffic with a long result hold and a full drain in the middle.
      for (int n = 0; n < RANDOM_HEADERS; n++) begin
         if (n % 100 == 0)
            send_gaps_on = ($urandom_range(0, 2) != 0);
         if (n == 300) begin
            hold_request = 1'b1;
            send_gaps_on = 1'b0;
         end
         if (n == 650)
            drain_results();
         send_header(random_header());
      end

      // Let the last results come out, then let the block settle before the final check.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flag_leftovers();

      $display("Checked %0d headers: ok %0d, version %0d, layer %0d, bitrate index %0d,",
               sb.checked, sb.fault_seen[FAULT_NONE], sb.fault_seen[FAULT_VERSION],
               sb.fault_seen[FAULT_LAYER], sb.fault_seen[FAULT_BITRATE]);
      $display("rate %0d, emphasis %0d, layer II pair %0d; input held off %0d cycles.",
               sb.fault_seen[FAULT_RATE], sb.fault_seen[FAULT_EMPHASIS],
               sb.fault_seen[FAULT_L2_PAIR], input_stall_cycles);
      if (sb.mismatches == 0)
         $display("audio_frame_header_check_top_tb passed");
      else
         $display("audio_frame_header_check_top_tb failed");
      $finish;
   end

endmodule

`default_nettype wire
